[src/mlp_backprop_train_step_defines.svh]
// assertion macros for the 2-2-1 perceptron training block
// the including module provides clk and rst_n
`ifndef MLP_BACKPROP_TRAIN_STEP_DEFINES_SVH
`define MLP_BACKPROP_TRAIN_STEP_DEFINES_SVH

// consequent checked in the cycle after the antecedent
`define MBP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mlp_backprop_train_step: check failed");

// consequent checked in the same cycle as the antecedent
`define MBP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mlp_backprop_train_step: check failed");

`endif

[src/mlp_bp_pkg.sv]
// shared types and constants for the 2-2-1 perceptron training block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mlp_bp_pkg;

    localparam int FRAC_BITS_DEF   = 12;
    localparam int SIG_ENTRIES_DEF = 256;

    localparam int WEIGHT_COUNT = 9;
    localparam int WEIGHT_W     = 16;
    localparam int IDX_W        = 4;
    localparam int CFG_W        = 13;

    localparam logic [CFG_W-1:0] LR_RESET    = 13'd2048;
    localparam logic [CFG_W-1:0] MOM_RESET   = 13'd3686;
    localparam logic [CFG_W-1:0] ALLOW_RESET = 13'd41;

    typedef enum logic [1:0] {
        ACT_LOAD  = 2'd0,
        ACT_INFER = 2'd1,
        ACT_TRAIN = 2'd2,
        ACT_RSVD  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        CFG_LEARN_RATE = 2'd0,
        CFG_MOMENTUM   = 2'd1,
        CFG_ALLOWANCE  = 2'd2,
        CFG_UNUSED     = 2'd3
    } cfg_index_t;

endpackage

`default_nettype wire

[src/mlp_backprop_train_step.sv]
// 2-2-1 sigmoid perceptron with backprop and momentum, one shared multiplier
// depends on mlp_bp_pkg, mlp_bp_sig_rom and mlp_backprop_train_step_defines.svh
//
// usage:
//   requests enter on in_valid/in_ready; in_ready is high only while idle, so
//   one request is in flight at a time. each request gives exactly one result
//   on out_valid/out_ready, held in an output register until taken.
//   cfg_valid/cfg_ready writes the learn rate, momentum or allowance by index;
//   cfg_ready is always high, writes are meant to happen while the block idles.
// steps of a request:
//   load   writes the weight if the index is in range, then goes to the done state
//   infer  3 units x (3 multiply/accumulate pairs + 2 sigmoid states),
//          then one error state and one done state
//   train  adds 8 delta multiplies and 27 update multiplies, each
//          a multiply state followed by a use state on the one multiplier
// a new request is taken only after the block has returned to idle.
// a stalled receiver holds the result; the block finishes its request and then
// waits in its done state, taking no new request until the result is taken.
// reset clears all weights and momentum terms and restores the register
// defaults; the sigmoid table is a constant and needs no fill.
`timescale 1ns / 1ps
`default_nettype none

module mlp_backprop_train_step #(
    parameter int FRAC_BITS   = mlp_bp_pkg::FRAC_BITS_DEF,
    parameter int SIG_ENTRIES = mlp_bp_pkg::SIG_ENTRIES_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire mlp_bp_pkg::action_t                   action,
    input  wire logic [mlp_bp_pkg::IDX_W-1:0]          weight_index,
    input  wire logic signed [mlp_bp_pkg::WEIGHT_W-1:0] weight_value,
    input  wire logic signed [15:0]                    x_first,
    input  wire logic signed [15:0]                    x_second,
    input  wire logic [mlp_bp_pkg::CFG_W-1:0]          target,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic [12:0]                                net_output,
    output logic                                       within_res,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire mlp_bp_pkg::cfg_index_t                cfg_index,
    input  wire logic [mlp_bp_pkg::CFG_W-1:0]          cfg_data
);

    import mlp_bp_pkg::*;

    `include "mlp_backprop_train_step_defines.svh"

    localparam int OW = 24;
    localparam int PW = 2 * OW;
    localparam int RW = 32;
    localparam int IW = (SIG_ENTRIES > 1) ? $clog2(SIG_ENTRIES) : 1;
    localparam int VW = ((FRAC_BITS > 15) ? FRAC_BITS : 15) + 6;
    localparam int SW = VW + IW + 1;
    localparam int SIG_OFS = 8 << FRAC_BITS;
    localparam logic signed [OW-1:0] ONE_V = OW'(1) << FRAC_BITS;

    localparam logic [2:0] OP_PY   = 3'd0;
    localparam logic [2:0] OP_DOUT = 3'd1;
    localparam logic [2:0] OP_BK0  = 3'd2;
    localparam logic [2:0] OP_P0   = 3'd3;
    localparam logic [2:0] OP_DH0  = 3'd4;
    localparam logic [2:0] OP_BK1  = 3'd5;
    localparam logic [2:0] OP_P1   = 3'd6;
    localparam logic [2:0] OP_DH1  = 3'd7;

    localparam logic [1:0] SUB_GAIN = 2'd0;
    localparam logic [1:0] SUB_TERM = 2'd1;
    localparam logic [1:0] SUB_MOM  = 2'd2;

    typedef enum logic [10:0] {
        S_IDLE = 11'b000_0000_0001,
        S_FMUL = 11'b000_0000_0010,
        S_FACC = 11'b000_0000_0100,
        S_FSIG = 11'b000_0000_1000,
        S_FLUT = 11'b000_0001_0000,
        S_ERR  = 11'b000_0010_0000,
        S_DMUL = 11'b000_0100_0000,
        S_DUSE = 11'b000_1000_0000,
        S_UMUL = 11'b001_0000_0000,
        S_UUSE = 11'b010_0000_0000,
        S_DONE = 11'b100_0000_0000
    } state_t;

    function automatic logic signed [WEIGHT_W-1:0] sat16(input logic signed [PW-1:0] v);
        if (v > PW'(32767))
            return 16'sd32767;
        else if (v < -PW'(32768))
            return -16'sd32768;
        else
            return v[WEIGHT_W-1:0];
    endfunction

    state_t state_reg;
    logic [1:0] lay_reg;
    logic [1:0] j_reg;
    logic [2:0] op_reg;
    logic [1:0] sub_reg;
    action_t act_reg;

    logic [CFG_W-1:0] lr_reg;
    logic [CFG_W-1:0] mom_reg;
    logic [CFG_W-1:0] allow_reg;

    logic signed [WEIGHT_W-1:0] w_reg [WEIGHT_COUNT];
    logic signed [WEIGHT_W-1:0] prev_reg [WEIGHT_COUNT];

    logic out_valid_reg;
    logic [12:0] net_out_reg;
    logic within_reg;
    logic [12:0] res_net_reg;
    logic res_within_reg;

    logic signed [OW-1:0] x0_reg, x1_reg;
    logic [CFG_W-1:0] tgt_reg;
    logic signed [PW-1:0] acc_reg;
    logic signed [PW-1:0] prod_reg;
    logic signed [OW-1:0] o0_reg, o1_reg, y_reg;
    logic signed [OW-1:0] t1_reg, t2_reg, dout_reg, dh0_reg, dh1_reg, g_reg;
    logic signed [RW-1:0] term_reg;

    logic signed [OW-1:0] mul_a, mul_b;
    logic signed [PW-1:0] prod_sh;
    logic signed [RW-1:0] prod_q;
    logic [IDX_W-1:0] fwd_idx, upd_idx, cur_idx;
    logic signed [WEIGHT_W-1:0] w_rd, prev_rd;
    logic signed [OW-1:0] fwd_src, upd_src, upd_delta;
    logic signed [WEIGHT_W-1:0] fwd_sat;
    logic signed [VW-1:0] sig_v;
    logic [SW-1:0] sig_scaled, sig_shift;
    logic [IW-1:0] sig_idx;
    logic [FRAC_BITS:0] sig_val;
    logic signed [OW-1:0] err_c, err_abs;
    logic signed [WEIGHT_W-1:0] dw_c, w_new_c;
    logic load_hit;
    logic out_load;

    assign in_ready   = (state_reg == S_IDLE);
    assign cfg_ready  = 1'b1;
    assign out_valid  = out_valid_reg;
    assign net_output = net_out_reg;
    assign within_res = within_reg;

    // weight addressing for the forward pass and the update pass
    assign fwd_idx = IDX_W'(3 * lay_reg + j_reg);
    assign upd_idx = (lay_reg == 2'd0) ? IDX_W'(6 + j_reg) : IDX_W'(3 * (lay_reg - 1) + j_reg);
    assign cur_idx = (state_reg == S_FMUL) ? fwd_idx : upd_idx;
    assign w_rd    = w_reg[cur_idx];
    assign prev_rd = prev_reg[cur_idx];

    always_comb
    begin
        if (lay_reg == 2'd2)
            fwd_src = (j_reg == 2'd0) ? o0_reg : ((j_reg == 2'd1) ? o1_reg : ONE_V);
        else
            fwd_src = (j_reg == 2'd0) ? x0_reg : ((j_reg == 2'd1) ? x1_reg : ONE_V);
        if (lay_reg == 2'd0)
        begin
            upd_src   = (j_reg == 2'd0) ? o0_reg : ((j_reg == 2'd1) ? o1_reg : ONE_V);
            upd_delta = dout_reg;
        end
        else
        begin
            upd_src   = (j_reg == 2'd0) ? x0_reg : ((j_reg == 2'd1) ? x1_reg : ONE_V);
            upd_delta = (lay_reg == 2'd1) ? dh0_reg : dh1_reg;
        end
    end

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_FMUL:
            begin
                mul_a = OW'(w_rd);
                mul_b = fwd_src;
            end
            S_DMUL:
            begin
                case (op_reg)
                    OP_PY:   begin mul_a = y_reg;         mul_b = ONE_V - y_reg;  end
                    OP_DOUT: begin mul_a = t1_reg;        mul_b = OW'(tgt_reg) - y_reg; end
                    OP_BK0:  begin mul_a = OW'(w_reg[6]); mul_b = dout_reg;       end
                    OP_P0:   begin mul_a = o0_reg;        mul_b = ONE_V - o0_reg; end
                    OP_BK1:  begin mul_a = OW'(w_reg[7]); mul_b = dout_reg;       end
                    OP_P1:   begin mul_a = o1_reg;        mul_b = ONE_V - o1_reg; end
                    default: begin mul_a = t2_reg;        mul_b = t1_reg;         end
                endcase
            end
            S_UMUL:
            begin
                case (sub_reg)
                    SUB_GAIN: begin mul_a = OW'(lr_reg); mul_b = upd_delta; end
                    SUB_TERM: begin mul_a = g_reg;       mul_b = upd_src;   end
                    default:  begin mul_a = OW'(mom_reg); mul_b = OW'(prev_rd); end
                endcase
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_sh = prod_reg >>> FRAC_BITS;
    assign prod_q  = prod_sh[RW-1:0];

    // sigmoid index: clamp the saturated sum into the table range
    assign fwd_sat    = sat16(acc_reg >>> FRAC_BITS);
    assign sig_v      = VW'(fwd_sat) + VW'(SIG_OFS);
    assign sig_scaled = SW'(unsigned'(sig_v)) * SW'(SIG_ENTRIES);
    assign sig_shift  = sig_scaled >> (FRAC_BITS + 4);

    always_comb
    begin
        if (sig_v < 0)
            sig_idx = '0;
        else if (sig_shift > SW'(SIG_ENTRIES - 1))
            sig_idx = IW'(SIG_ENTRIES - 1);
        else
            sig_idx = sig_shift[IW-1:0];
    end

    mlp_bp_sig_rom #(
        .FRAC_BITS   (FRAC_BITS),
        .SIG_ENTRIES (SIG_ENTRIES)
    ) u_sig_rom (
        .clk   (clk),
        .idx   (sig_idx),
        .value (sig_val)
    );

    assign err_c   = OW'(tgt_reg) - y_reg;
    assign err_abs = (err_c < 0) ? -err_c : err_c;
    assign dw_c    = sat16(PW'(term_reg) + PW'(prod_q));
    assign w_new_c = sat16(PW'(w_rd) + PW'(dw_c));
    assign load_hit = (weight_index < IDX_W'(WEIGHT_COUNT));
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            lay_reg       <= '0;
            j_reg         <= '0;
            op_reg        <= OP_PY;
            sub_reg       <= SUB_GAIN;
            act_reg       <= ACT_LOAD;
            lr_reg        <= LR_RESET;
            mom_reg       <= MOM_RESET;
            allow_reg     <= ALLOW_RESET;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < WEIGHT_COUNT; i++)
            begin
                w_reg[i]    <= '0;
                prev_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_LEARN_RATE: lr_reg    <= cfg_data;
                    CFG_MOMENTUM:   mom_reg   <= cfg_data;
                    CFG_ALLOWANCE:  allow_reg <= cfg_data;
                    default:        ;
                endcase
            end

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        act_reg <= action;
                        lay_reg <= '0;
                        j_reg   <= '0;
                        if (action == ACT_LOAD)
                        begin
                            if (load_hit)
                            begin
                                w_reg[weight_index]    <= weight_value;
                                prev_reg[weight_index] <= '0;
                            end
                            state_reg <= S_DONE;
                        end
                        else
                            state_reg <= S_FMUL;
                    end
                end
                S_FMUL:
                    state_reg <= S_FACC;
                S_FACC:
                begin
                    if (j_reg == 2'd2)
                    begin
                        j_reg     <= '0;
                        state_reg <= S_FSIG;
                    end
                    else
                    begin
                        j_reg     <= j_reg + 2'd1;
                        state_reg <= S_FMUL;
                    end
                end
                S_FSIG:
                    state_reg <= S_FLUT;
                S_FLUT:
                begin
                    if (lay_reg == 2'd2)
                    begin
                        lay_reg   <= '0;
                        state_reg <= S_ERR;
                    end
                    else
                    begin
                        lay_reg   <= lay_reg + 2'd1;
                        state_reg <= S_FMUL;
                    end
                end
                S_ERR:
                begin
                    op_reg    <= OP_PY;
                    state_reg <= (act_reg == ACT_TRAIN) ? S_DMUL : S_DONE;
                end
                S_DMUL:
                    state_reg <= S_DUSE;
                S_DUSE:
                begin
                    if (op_reg == OP_DH1)
                    begin
                        lay_reg   <= '0;
                        j_reg     <= '0;
                        sub_reg   <= SUB_GAIN;
                        state_reg <= S_UMUL;
                    end
                    else
                    begin
                        op_reg    <= op_reg + 3'd1;
                        state_reg <= S_DMUL;
                    end
                end
                S_UMUL:
                    state_reg <= S_UUSE;
                S_UUSE:
                begin
                    if (sub_reg == SUB_MOM)
                    begin
                        prev_reg[upd_idx] <= dw_c;
                        w_reg[upd_idx]    <= w_new_c;
                        sub_reg           <= SUB_GAIN;
                        if (j_reg == 2'd2)
                        begin
                            j_reg <= '0;
                            if (lay_reg == 2'd2)
                                state_reg <= S_DONE;
                            else
                            begin
                                lay_reg   <= lay_reg + 2'd1;
                                state_reg <= S_UMUL;
                            end
                        end
                        else
                        begin
                            j_reg     <= j_reg + 2'd1;
                            state_reg <= S_UMUL;
                        end
                    end
                    else
                    begin
                        sub_reg   <= sub_reg + 2'd1;
                        state_reg <= S_UMUL;
                    end
                end
                S_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                        state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        if (out_load)
        begin
            net_out_reg <= res_net_reg;
            within_reg  <= res_within_reg;
        end
        case (state_reg)
            S_IDLE:
            begin
                x0_reg         <= OW'(x_first);
                x1_reg         <= OW'(x_second);
                tgt_reg        <= target;
                acc_reg        <= '0;
                res_net_reg    <= '0;
                res_within_reg <= 1'b0;
            end
            S_FACC:
                acc_reg <= acc_reg + prod_reg;
            S_FLUT:
            begin
                acc_reg <= '0;
                if (lay_reg == 2'd0)
                    o0_reg <= OW'(sig_val);
                else if (lay_reg == 2'd1)
                    o1_reg <= OW'(sig_val);
                else
                    y_reg <= OW'(sig_val);
            end
            S_ERR:
            begin
                res_net_reg    <= y_reg[12:0];
                res_within_reg <= (err_abs < OW'(allow_reg));
            end
            S_DUSE:
            begin
                case (op_reg) inside
                    OP_PY, OP_BK0, OP_BK1: t1_reg   <= prod_q[OW-1:0];
                    OP_P0, OP_P1:          t2_reg   <= prod_q[OW-1:0];
                    OP_DOUT:               dout_reg <= prod_q[OW-1:0];
                    OP_DH0:                dh0_reg  <= prod_q[OW-1:0];
                    default:               dh1_reg  <= prod_q[OW-1:0];
                endcase
            end
            S_UUSE:
            begin
                if (sub_reg == SUB_GAIN)
                    g_reg <= prod_q[OW-1:0];
                else if (sub_reg == SUB_TERM)
                    term_reg <= prod_q;
            end
            default:
                ;
        endcase
    end

    `MBP_ASSERT_NEXT(a_busy_after_req, in_valid && in_ready, !in_ready)
    `MBP_ASSERT_NEXT(a_load_to_done, in_valid && in_ready && action == ACT_LOAD, state_reg == S_DONE)
    `MBP_ASSERT_NOW(a_result_from_done, $rose(out_valid_reg), $past(state_reg == S_DONE))
    `MBP_ASSERT_NOW(a_lane_bound, state_reg != S_IDLE, j_reg != 2'd3 && lay_reg != 2'd3)

endmodule

`default_nettype wire

[src/mlp_bp_sig_rom.sv]
// clamped sigmoid lookup table with registered read
// table contents are computed at elaboration from the two parameters
`timescale 1ns / 1ps
`default_nettype none

module mlp_bp_sig_rom #(
    parameter int FRAC_BITS   = 12,
    parameter int SIG_ENTRIES = 256,
    localparam int IW = (SIG_ENTRIES > 1) ? $clog2(SIG_ENTRIES) : 1
) (
    input  wire logic                 clk,
    input  wire logic [IW-1:0]        idx,
    output logic      [FRAC_BITS:0]   value
);

    typedef logic [FRAC_BITS:0] sig_tab_t [SIG_ENTRIES];
    typedef logic [63:0] u64_t;

    // restoring division, only used while the table is built
    function automatic u64_t udiv(input u64_t num, input u64_t den);
        u64_t quo;
        u64_t rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[62:0], num[b]};
            if (rem >= den)
            begin
                rem    = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // e^(num/den) in Q30 by a truncated series
    function automatic u64_t exp_q30(input u64_t num, input u64_t den);
        u64_t term;
        u64_t sum;
        term = u64_t'(1) << 30;
        sum  = term;
        for (int i = 1; i <= 24; i++)
        begin
            term = udiv(term * num, den * u64_t'(i));
            sum  = sum + term;
        end
        return sum;
    endfunction

    // entry k holds 2^F / (1 + e^-c) at the bin midpoint c, rounded to nearest
    function automatic sig_tab_t build_tab();
        sig_tab_t tab;
        longint   m;
        u64_t     a;
        u64_t     t;
        u64_t     den;
        u64_t     num;
        for (int k = 0; k < SIG_ENTRIES; k++)
        begin
            m = 16 * longint'(k) + 8 - 8 * longint'(SIG_ENTRIES);
            a = u64_t'((m < 0) ? -m : m);
            // e^-|c| as the eighth power of e^(-|c|/8)
            t = udiv(u64_t'(1) << 60, exp_q30(a, u64_t'(8 * SIG_ENTRIES)));
            for (int r = 0; r < 3; r++)
                t = (t * t) >> 30;
            den = (u64_t'(1) << 30) + t;
            num = (m >= 0) ? (u64_t'(1) << 30) : t;
            tab[k] = (FRAC_BITS + 1)'(udiv((num << FRAC_BITS) + (den >> 1), den));
        end
        return tab;
    endfunction

    localparam sig_tab_t SIG_TAB = build_tab();

    always_ff @(posedge clk)
    begin
        value <= SIG_TAB[idx];
    end

endmodule

`default_nettype wire

[tb/mlp_backprop_train_step_test.sv]
// testbench for the 2-2-1 perceptron training block: random and directed requests,
// results checked against a predictor kept in a small scoreboard class
// depends on mlp_bp_pkg and mlp_backprop_train_step
`timescale 1ns / 1ps

module mlp_backprop_train_step_test;
    import mlp_bp_pkg::*;

    localparam int FB = FRAC_BITS_DEF;
    localparam int NSIG = SIG_ENTRIES_DEF;
    localparam int STALL_LIMIT = 2000;

    typedef struct {
        logic [12:0] net;
        logic        in_bound;
    } mlp_result_t;

    class mlp_scoreboard;
        longint unsigned sig_lut[NSIG];
        longint weights[WEIGHT_COUNT];
        longint prev_dw[WEIGHT_COUNT];
        longint rate, mom, allow;
        mlp_result_t pending[$];
        int errors;

        function new();
            longint m, a, den, num, t, term, sum;
            for (int k = 0; k < NSIG; k++) begin
                m = 16 * k + 8 - 8 * NSIG;
                a = (m < 0) ? -m : m;
                term = 64'd1 << 30;
                sum = term;
                for (int i = 1; i <= 24; i++) begin
                    term = longint'(longint'(unsigned'(term * a)) / (8 * NSIG * i));
                    sum += term;
                end
                t = (64'd1 << 60) / sum;
                for (int r = 0; r < 3; r++)
                    t = (t * t) >> 30;
                den = (64'd1 << 30) + t;
                num = (m >= 0) ? (64'd1 << 30) : t;
                sig_lut[k] = ((num << FB) + den / 2) / den;
            end
            errors = 0;
            clear();
        endfunction

        function void clear();
            foreach (weights[i]) begin
                weights[i] = 0;
                prev_dw[i] = 0;
            end
            rate = LR_RESET;
            mom = MOM_RESET;
            allow = ALLOW_RESET;
        endfunction

        function longint sat16(longint v);
            if (v > 32767) return 32767;
            if (v < -32768) return -32768;
            return v;
        endfunction

        function longint sigmoid(longint x);
            longint v, idx;
            v = x + (longint'(8) << FB);
            idx = (v < 0) ? 0 : ((v * NSIG) >>> (FB + 4));
            if (idx > NSIG - 1) idx = NSIG - 1;
            return longint'(sig_lut[idx]);
        endfunction

        function void update_weight(int i, longint d, longint s);
            longint g, dw;
            g = (rate * d) >>> FB;
            dw = sat16(((g * s) >>> FB) + ((mom * prev_dw[i]) >>> FB));
            prev_dw[i] = dw;
            weights[i] = sat16(weights[i] + dw);
        endfunction

        function void set_reg(cfg_index_t idx, logic [CFG_W-1:0] val);
            case (idx)
                CFG_LEARN_RATE: rate = val;
                CFG_MOMENTUM:   mom = val;
                CFG_ALLOWANCE:  allow = val;
                default: ;
            endcase
        endfunction

        // predict the result of an accepted request and update the weights
        function void note_request(action_t act, logic [3:0] widx, logic signed [15:0] wval,
                                   logic signed [15:0] x0, logic signed [15:0] x1,
                                   logic [12:0] tgt);
            longint x[3], o[3], dh[2];
            longint s, y, err, dout, back, one;
            mlp_result_t r;
            one = longint'(1) << FB;
            if (act == ACT_LOAD) begin
                if (widx <= 8) begin
                    weights[widx] = wval;
                    prev_dw[widx] = 0;
                end
                r.net = 0;
                r.in_bound = 0;
                pending.push_back(r);
                return;
            end
            x[0] = x0;
            x[1] = x1;
            x[2] = one;
            for (int h = 0; h < 2; h++) begin
                s = 0;
                for (int j = 0; j < 3; j++) s += weights[h*3+j] * x[j];
                o[h] = sigmoid(sat16(s >>> FB));
            end
            o[2] = one;
            s = 0;
            for (int j = 0; j < 3; j++) s += weights[6+j] * o[j];
            y = sigmoid(sat16(s >>> FB));
            err = longint'(tgt) - y;
            r.net = y[12:0];
            r.in_bound = (((err < 0) ? -err : err) < allow);
            pending.push_back(r);
            if (act == ACT_TRAIN) begin
                dout = (((y * (one - y)) >>> FB) * err) >>> FB;
                for (int h = 0; h < 2; h++) begin
                    back = (weights[6+h] * dout) >>> FB;
                    dh[h] = (((o[h] * (one - o[h])) >>> FB) * back) >>> FB;
                end
                for (int j = 0; j < 3; j++) update_weight(6 + j, dout, o[j]);
                for (int h = 0; h < 2; h++)
                    for (int j = 0; j < 3; j++) update_weight(h*3 + j, dh[h], x[j]);
            end
        endfunction

        task report(string msg);
            errors++;
            $display("mismatch at %0t: %s", $time, msg);
        endtask

        task check(logic [12:0] net, logic in_bound);
            mlp_result_t e;
            if (pending.size() == 0) begin
                report($sformatf("unexpected result net_output=%0d", net));
                return;
            end
            e = pending.pop_front();
            if (net !== e.net) report($sformatf("net_output %0d, want %0d", net, e.net));
            if (in_bound !== e.in_bound)
                report($sformatf("within_res %0b, want %0b", in_bound, e.in_bound));
        endtask
    endclass

    logic clk, rst_n;
    logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
    action_t action;
    logic [3:0] weight_index;
    logic signed [15:0] weight_value, x_first, x_second;
    logic [12:0] target, net_output, cfg_data;
    logic within_res;
    cfg_index_t cfg_index;
    logic quiet;
    int idle_cycles = 0;

    mlp_scoreboard sb;

    mlp_backprop_train_step DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .action(action), .weight_index(weight_index), .weight_value(weight_value),
        .x_first(x_first), .x_second(x_second), .target(target),
        .out_valid(out_valid), .out_ready(out_ready),
        .net_output(net_output), .within_res(within_res),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
        if (rst_n && out_valid && out_ready) sb.check(net_output, within_res);

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiver stalls in bursts
    initial begin
        out_ready = 1;
        forever begin
            @(negedge clk);
            if (!quiet && $urandom_range(0, 3) == 0) begin
                out_ready = 0;
                repeat ($urandom_range(1, 14)) @(negedge clk);
            end
            out_ready = 1;
            repeat ($urandom_range(1, 20)) @(negedge clk);
        end
    end

    task automatic send_request(action_t act, logic [3:0] widx, logic signed [15:0] wval,
                                logic signed [15:0] x0, logic signed [15:0] x1,
                                logic [12:0] tgt);
        @(negedge clk);
        in_valid = 1;
        action = act;
        weight_index = widx;
        weight_value = wval;
        x_first = x0;
        x_second = x1;
        target = tgt;
        do @(posedge clk); while (!in_ready);
        sb.note_request(act, widx, wval, x0, x1, tgt);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            @(negedge clk);
            in_valid = 0;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
    endtask

    // drain all results, then let the block settle before a register write
    task automatic drain();
        @(negedge clk);
        in_valid = 0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [12:0] val);
        @(negedge clk);
        cfg_valid = 1;
        cfg_index = idx;
        cfg_data = val;
        do @(posedge clk); while (!cfg_ready);
        sb.set_reg(idx, val);
        @(negedge clk);
        cfg_valid = 0;
    endtask

    function automatic logic signed [15:0] rand_val();
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return $signed(16'($urandom_range(0, 16383))) - 16'sd8192;
            2: return $signed(16'($urandom_range(0, 2047))) - 16'sd1024;
            default: return ($urandom_range(0, 1)) ? 16'sh7fff : 16'sh8000;
        endcase
    endfunction

    task automatic random_requests(int count);
        action_t act;
        logic [12:0] tgt;
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(0, 9))
                0, 1: act = ACT_LOAD;
                2, 3: act = ACT_INFER;
                4: act = action_t'($urandom_range(0, 3));
                default: act = ACT_TRAIN;
            endcase
            tgt = ($urandom_range(0, 7) == 0) ? 13'($urandom) : 13'($urandom_range(0, 4096));
            send_request(act, ($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'($urandom_range(0, 8)),
                         rand_val(), rand_val(), rand_val(), tgt);
        end
    endtask

    initial begin
        sb = new();
        quiet = 0;
        rst_n = 0;
        in_valid = 0;
        action = ACT_LOAD;
        weight_index = 0;
        weight_value = 0;
        x_first = 0;
        x_second = 0;
        target = 0;
        cfg_valid = 0;
        cfg_index = CFG_LEARN_RATE;
        cfg_data = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: zero weights, extremes, every action, ignored load
        send_request(ACT_INFER, 0, 0, 0, 0, 2048);
        send_request(ACT_TRAIN, 0, 0, 16'sh7fff, 16'sh8000, 13'h1fff);
        for (int i = 0; i < 9; i++)
            send_request(ACT_LOAD, 4'(i), (i % 2) ? 16'sh7fff : 16'sh8000, 0, 0, 0);
        send_request(ACT_LOAD, 4'd15, 16'sh1234, 0, 0, 0);
        send_request(ACT_LOAD, 4'd9, 16'sh5555, 0, 0, 0);
        send_request(ACT_INFER, 0, 0, 16'sh7fff, 16'sh7fff, 0);
        send_request(ACT_RSVD, 0, 0, 16'sh8000, 16'sh8000, 4096);
        send_request(ACT_TRAIN, 0, 0, 16'sh1000, 16'shf000, 4096);
        send_request(ACT_TRAIN, 0, 0, 16'sh0800, 16'sh0400, 0);
        send_request(ACT_LOAD, 4'd6, 16'sh1000, 0, 0, 0);
        send_request(ACT_TRAIN, 0, 0, 16'shffff, 16'sh0001, 13'h1fff);
        send_request(ACT_INFER, 0, 0, 16'sh2000, 16'she000, 2000);
        drain();

        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                1: begin
                    write_reg(CFG_LEARN_RATE, 0);
                    write_reg(CFG_MOMENTUM, 0);
                    write_reg(CFG_ALLOWANCE, 0);
                end
                2: begin
                    write_reg(CFG_LEARN_RATE, 4096);
                    write_reg(CFG_MOMENTUM, 4096);
                    write_reg(CFG_ALLOWANCE, 4096);
                    write_reg(CFG_UNUSED, 13'h0abc);
                end
                3: begin
                    write_reg(CFG_LEARN_RATE, 13'h1fff);
                    write_reg(CFG_MOMENTUM, 13'h1fff);
                    write_reg(CFG_ALLOWANCE, 13'h1fff);
                end
                4: begin
                    write_reg(CFG_LEARN_RATE, 13'($urandom));
                    write_reg(CFG_MOMENTUM, 13'($urandom_range(0, 4096)));
                    write_reg(CFG_ALLOWANCE, 13'($urandom_range(0, 512)));
                    quiet = 1;
                end
                default: ;
            endcase
            random_requests(160);
            drain();
        end

        repeat (120) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
